// ===== rtl/gpmd_pkg.sv =====
`timescale 1ns / 1ps

package gpmd_pkg;

	// Field widths
	localparam int unsigned METHOD_W = 13;
	localparam int unsigned SUBCH_W  = 3;
	localparam int unsigned COUNT_W  = 13;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned ADDR_W   = 40;
	localparam int unsigned MODE_W   = 3;

	// Header mode codes, bits 31:29
	localparam logic [MODE_W-1:0] MODE_INCR      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_NON_INCR  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_INLINE    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_INCR_ONCE = 3'd5;

	// Reset value of the puller method limit
	localparam logic [METHOD_W-1:0] PULLER_LIMIT_RST = 13'd64;

	// Decoder state carried between items
	typedef struct packed {
		logic [METHOD_W-1:0] method;
		logic [SUBCH_W-1:0]  subch;
		logic [COUNT_W-1:0]  pending;
		logic                hold_method;
		logic                hold_after_first;
	} dec_state_t;

	// One method call
	typedef struct packed {
		logic                valid;
		logic [METHOD_W-1:0] method_index;
		logic [SUBCH_W-1:0]  subchannel_id;
		logic [WORD_W-1:0]   argument_value;
		logic [COUNT_W-1:0]  remaining_count;
		logic                is_last;
		logic                to_puller;
		logic [ADDR_W-1:0]   segment_address;
	} call_t;

endpackage

// ===== rtl/gpmd_decode.sv =====
`timescale 1ns / 1ps

module gpmd_decode (
	input  logic [gpmd_pkg::WORD_W-1:0]   command_word,
	input  logic [gpmd_pkg::ADDR_W-1:0]   word_address,
	input  logic [gpmd_pkg::METHOD_W-1:0] puller_limit,
	input  gpmd_pkg::dec_state_t          state_cur,
	output gpmd_pkg::dec_state_t          state_nxt,
	output gpmd_pkg::call_t               call
);

	logic [gpmd_pkg::MODE_W-1:0]   mode;
	logic [gpmd_pkg::COUNT_W-1:0]  hdr_count;
	logic [gpmd_pkg::METHOD_W-1:0] hdr_method;
	logic [gpmd_pkg::SUBCH_W-1:0]  hdr_subch;

	// Slice header fields
	assign hdr_method = command_word[12:0];
	assign hdr_subch  = command_word[15:13];
	assign hdr_count  = command_word[28:16];
	assign mode       = command_word[31:29];

	// Decode a data word or a header
	always_comb begin
		state_nxt = state_cur;
		call      = '0;
		if (state_cur.pending != '0) begin
			call.valid           = 1'b1;
			call.method_index    = state_cur.method;
			call.subchannel_id   = state_cur.subch;
			call.argument_value  = command_word;
			call.remaining_count = state_cur.pending;
			call.is_last         = (state_cur.pending == gpmd_pkg::COUNT_W'(1));
			call.to_puller       = (state_cur.method < puller_limit);
			call.segment_address = word_address;
			if (!state_cur.hold_method) begin
				state_nxt.method = state_cur.method + gpmd_pkg::METHOD_W'(1);
			end
			if (state_cur.hold_after_first) begin
				state_nxt.hold_method = 1'b1;
			end
			state_nxt.pending = state_cur.pending - gpmd_pkg::COUNT_W'(1);
		end else begin
			case (mode)
				gpmd_pkg::MODE_INCR, gpmd_pkg::MODE_NON_INCR, gpmd_pkg::MODE_INCR_ONCE: begin
					state_nxt.method           = hdr_method;
					state_nxt.subch            = hdr_subch;
					state_nxt.pending          = hdr_count;
					state_nxt.hold_method      = (mode == gpmd_pkg::MODE_NON_INCR);
					state_nxt.hold_after_first = (mode == gpmd_pkg::MODE_INCR_ONCE);
				end
				gpmd_pkg::MODE_INLINE: begin
					state_nxt.method           = hdr_method;
					state_nxt.subch            = hdr_subch;
					state_nxt.hold_method      = 1'b1;
					state_nxt.hold_after_first = 1'b0;
					call.valid                 = 1'b1;
					call.method_index          = hdr_method;
					call.subchannel_id         = hdr_subch;
					call.argument_value        = {{(gpmd_pkg::WORD_W-gpmd_pkg::COUNT_W){1'b0}},
						hdr_count};
					call.remaining_count       = '0;
					call.is_last               = 1'b1;
					call.to_puller             = (hdr_method < puller_limit);
					call.segment_address       = '0;
				end
				default: begin
					// ignore unknown modes
					state_nxt = state_cur;
				end
			endcase
		end
	end

endmodule

// ===== rtl/gpu_pushbuffer_method_decoder.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Fields (low bit up)
// s_axis    in   tdata: command_word[31:0], word_address[71:32], zero pad to 80
// m_axis    out  tdata: method_index[12:0], subchannel_id[15:13], argument_value[47:16],
//                       remaining_count[60:48], segment_address[100:61], zero pad to 104
//                tlast: is_last   tuser: to_puller
// cfg       in   cfg_wen / cfg_wdata: puller_method_limit
//
// One item per cycle sustained while m_axis_tready is high; each item passes through
// the input register, where the header decode and count update run, and then sits
// in the result register.
// Reset clears the decoder state, the valid flags and sets the puller limit to 64.
// A stalled result holds the result register; the input register still takes an
// item that produces no result.

module gpu_pushbuffer_method_decoder (
	input  logic         clk,
	input  logic         arst_n,
	// command_word[31:0], word_address[71:32]
	input  logic [79:0]  s_axis_tdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// method_index, subchannel_id, argument_value, remaining_count, segment_address
	output logic [103:0] m_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic         m_axis_tlast,
	// to_puller
	output logic [0:0]   m_axis_tuser,
	input  logic         cfg_wen,
	input  logic [12:0]  cfg_wdata
);

	logic                          valid_s1;
	logic [gpmd_pkg::WORD_W-1:0]   word_s1;
	logic [gpmd_pkg::ADDR_W-1:0]   addr_s1;
	logic [gpmd_pkg::METHOD_W-1:0] limit_q;
	gpmd_pkg::dec_state_t          state_q;
	gpmd_pkg::dec_state_t          state_nxt;
	gpmd_pkg::call_t               call;
	gpmd_pkg::call_t               out_q;
	logic                          out_free;
	logic                          advance;

	// Stage handshake
	assign out_free      = !out_q.valid || m_axis_tready;
	assign advance       = valid_s1 && (out_free || !call.valid);
	assign s_axis_tready = !valid_s1 || advance;

	// Hold the puller limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= gpmd_pkg::PULLER_LIMIT_RST;
		end else if (cfg_wen) begin
			limit_q <= cfg_wdata;
		end
	end

	// Capture the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			word_s1 <= s_axis_tdata[31:0];
			addr_s1 <= s_axis_tdata[71:32];
		end
	end

	gpmd_decode u_decode (
		.command_word (word_s1),
		.word_address (addr_s1),
		.puller_limit (limit_q),
		.state_cur    (state_q),
		.state_nxt    (state_nxt),
		.call         (call)
	);

	// Advance the decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Load or drain the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (out_free) begin
			if (advance) begin
				out_q <= call;
			end else begin
				out_q.valid <= 1'b0;
			end
		end
	end

	// Pack the result item
	assign m_axis_tvalid = out_q.valid;
	assign m_axis_tlast  = out_q.is_last;
	assign m_axis_tuser  = out_q.to_puller;
	assign m_axis_tdata  = {3'b000, out_q.segment_address, out_q.remaining_count,
		out_q.argument_value, out_q.subchannel_id, out_q.method_index};

endmodule
